@@ hdl/modular_exponentiation_core_macros.svh @@
// Assertion macros for the checker file of the modular exponentiation core.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef MODULAR_EXPONENTIATION_CORE_MACROS_SVH
`define MODULAR_EXPONENTIATION_CORE_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define MEC_ASSERT_HOLDS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// When the first condition holds, the second must hold in the next cycle.
`define MEC_ASSERT_NEXT(label, cond, expect_next, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (cond) |=> (expect_next)) else $error(msg);

`endif

@@ hdl/mexp_pkg.sv @@
// Shared types and constants of the modular exponentiation core.
// Used by the controller, the datapath and the top level; depends on nothing.
package mexp_pkg;

    localparam int WORD_BITS_DEF = 32;
    localparam int FIELD_BITS    = 32;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_INIT,
        ST_BIT_SEL,
        ST_MUL_ACC,
        ST_ACC_WB,
        ST_MUL_SQ,
        ST_SQ_WB,
        ST_FINISH
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_RED_STEP,
        OP_RED_DONE,
        OP_MUL_INIT_ACC,
        OP_MUL_INIT_SQ,
        OP_MUL_STEP,
        OP_ACC_WB,
        OP_SQ_WB,
        OP_OUT
    } op_t;

    typedef struct packed {
        op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic exp_lsb;
    } dp_status_t;

endpackage

@@ hdl/mexp_datapath.sv @@
// Datapath of the modular exponentiation core: operand registers, the bit-serial
// remainder step and the shift-and-add modular multiplier. Depends on mexp_pkg.
module mexp_datapath #(
    parameter int WordBits = mexp_pkg::WORD_BITS_DEF
) (
    input  logic                            clk,
    input  mexp_pkg::dp_cmd_t               cmd,
    output mexp_pkg::dp_status_t            status,
    input  logic [mexp_pkg::FIELD_BITS-1:0] base,
    input  logic [mexp_pkg::FIELD_BITS-1:0] exponent,
    input  logic [mexp_pkg::FIELD_BITS-1:0] modulus,
    output logic [mexp_pkg::FIELD_BITS-1:0] result
);
    import mexp_pkg::*;

    logic [WordBits-1:0] m_reg, m_next;
    logic [WordBits-1:0] e_reg, e_next;
    logic [WordBits-1:0] acc_reg, acc_next;
    logic [WordBits-1:0] sq_reg, sq_next;
    logic [WordBits-1:0] x_reg, x_next;
    logic [WordBits-1:0] y_reg, y_next;
    logic [WordBits-1:0] p_reg, p_next;
    logic [FIELD_BITS-1:0] result_reg, result_next;

    logic [63:0]         base_ext, exp_ext, mod_ext, acc_ext;
    logic [WordBits:0]   rem2, rem2_sub;
    logic [WordBits:0]   sum_px, sum_xx, sub_px, sub_xx;
    logic [WordBits-1:0] add_px, add_xx, red_val, one_mod;
    logic                mod_zero;

    // Operands are taken at the internal word width, zero-extended or truncated.
    assign base_ext = 64'(base);
    assign exp_ext  = 64'(exponent);
    assign mod_ext  = 64'(modulus);
    assign acc_ext  = 64'(acc_reg);

    assign mod_zero = (m_reg == '0);
    assign one_mod  = (m_reg == WordBits'(1)) ? '0 : WordBits'(1);

    // One step of the remainder of the base: shift in the next bit, subtract once.
    assign rem2     = {p_reg, y_reg[WordBits-1]};
    assign rem2_sub = rem2 - {1'b0, m_reg};
    assign red_val  = (rem2 >= {1'b0, m_reg}) ? rem2_sub[WordBits-1:0] : rem2[WordBits-1:0];

    // Two independent modular additions: partial product plus multiplicand, and doubling.
    assign sum_px = {1'b0, p_reg} + {1'b0, x_reg};
    assign sub_px = sum_px - {1'b0, m_reg};
    assign add_px = (sum_px >= {1'b0, m_reg}) ? sub_px[WordBits-1:0] : sum_px[WordBits-1:0];
    assign sum_xx = {1'b0, x_reg} + {1'b0, x_reg};
    assign sub_xx = sum_xx - {1'b0, m_reg};
    assign add_xx = (sum_xx >= {1'b0, m_reg}) ? sub_xx[WordBits-1:0] : sum_xx[WordBits-1:0];

    always_comb
    begin
        m_next      = m_reg;
        e_next      = e_reg;
        acc_next    = acc_reg;
        sq_next     = sq_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        p_next      = p_reg;
        result_next = result_reg;
        case (cmd.op)
            OP_LOAD:
            begin
                m_next = mod_ext[WordBits-1:0];
                e_next = exp_ext[WordBits-1:0];
                y_next = base_ext[WordBits-1:0];
                p_next = '0;
            end
            OP_RED_STEP:
            begin
                p_next = red_val;
                y_next = {y_reg[WordBits-2:0], 1'b0};
            end
            OP_RED_DONE:
            begin
                sq_next  = p_reg;
                acc_next = one_mod;
            end
            OP_MUL_INIT_ACC:
            begin
                x_next = acc_reg;
                y_next = sq_reg;
                p_next = '0;
            end
            OP_MUL_INIT_SQ:
            begin
                x_next = sq_reg;
                y_next = sq_reg;
                p_next = '0;
            end
            OP_MUL_STEP:
            begin
                if (y_reg[0])
                begin
                    p_next = add_px;
                end
                x_next = add_xx;
                y_next = {1'b0, y_reg[WordBits-1:1]};
            end
            OP_ACC_WB:
            begin
                // The squaring follows at once, so its operands are set up here too.
                acc_next = p_reg;
                x_next   = sq_reg;
                y_next   = sq_reg;
                p_next   = '0;
            end
            OP_SQ_WB:
            begin
                sq_next = p_reg;
                e_next  = {1'b0, e_reg[WordBits-1:1]};
            end
            OP_OUT:
            begin
                result_next = mod_zero ? '0 : acc_ext[FIELD_BITS-1:0];
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        m_reg      <= m_next;
        e_reg      <= e_next;
        acc_reg    <= acc_next;
        sq_reg     <= sq_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        p_reg      <= p_next;
        result_reg <= result_next;
    end

    assign status.exp_lsb = e_reg[0];
    assign result         = result_reg;

endmodule

@@ hdl/mexp_ctrl.sv @@
// Controller of the modular exponentiation core: sequences the reduction, the
// multiplications per exponent bit and the output handshake. Depends on mexp_pkg.
module mexp_ctrl #(
    parameter int WordBits = mexp_pkg::WORD_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  mexp_pkg::dp_status_t status,
    output mexp_pkg::dp_cmd_t    cmd
);
    import mexp_pkg::*;

    localparam int CntW = $clog2(WordBits);

    state_t          state_reg, state_next;
    logic [CntW-1:0] cnt_reg, cnt_next;
    logic [CntW-1:0] ecnt_reg, ecnt_next;
    logic            out_valid_reg, out_valid_next;
    logic            cnt_last, ecnt_last;

    assign cnt_last  = (cnt_reg == CntW'(WordBits - 1));
    assign ecnt_last = (ecnt_reg == CntW'(WordBits - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            ecnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            ecnt_reg      <= ecnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        ecnt_next      = ecnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd.op         = OP_NONE;
        in_ready       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    cnt_next   = '0;
                    ecnt_next  = '0;
                    state_next = ST_REDUCE;
                end
            end
            ST_REDUCE:
            begin
                cmd.op   = OP_RED_STEP;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_last)
                begin
                    state_next = ST_INIT;
                end
            end
            ST_INIT:
            begin
                cmd.op     = OP_RED_DONE;
                state_next = ST_BIT_SEL;
            end
            ST_BIT_SEL:
            begin
                cnt_next = '0;
                if (status.exp_lsb)
                begin
                    cmd.op     = OP_MUL_INIT_ACC;
                    state_next = ST_MUL_ACC;
                end
                else
                begin
                    cmd.op     = OP_MUL_INIT_SQ;
                    state_next = ST_MUL_SQ;
                end
            end
            ST_MUL_ACC:
            begin
                cmd.op   = OP_MUL_STEP;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_last)
                begin
                    state_next = ST_ACC_WB;
                end
            end
            ST_ACC_WB:
            begin
                cmd.op     = OP_ACC_WB;
                cnt_next   = '0;
                state_next = ST_MUL_SQ;
            end
            ST_MUL_SQ:
            begin
                cmd.op   = OP_MUL_STEP;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_last)
                begin
                    state_next = ST_SQ_WB;
                end
            end
            ST_SQ_WB:
            begin
                cmd.op    = OP_SQ_WB;
                ecnt_next = ecnt_reg + 1'b1;
                if (ecnt_last)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_BIT_SEL;
                end
            end
            ST_FINISH:
            begin
                // The result register may be reloaded once its word has been taken.
                if (!out_valid_reg || out_ready)
                begin
                    cmd.op         = OP_OUT;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

@@ hdl/modular_exponentiation_core.sv @@
// Modular exponentiation core: each input word (base, exponent, modulus) yields one
// output word, base to the power of exponent modulo modulus; a zero modulus gives 0.
// Items are processed one at a time. The base is first reduced by a bit-serial
// remainder; then each of the WordBits exponent bits costs a squaring and, for a
// set bit, a multiplication, each on the shared shift-and-add modular multiplier
// at one multiplier bit per cycle. A finished word waits in the output register,
// and the next input word is taken while it waits.
module modular_exponentiation_core #(
    parameter int WordBits = mexp_pkg::WORD_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [mexp_pkg::FIELD_BITS-1:0] base,
    input  logic [mexp_pkg::FIELD_BITS-1:0] exponent,
    input  logic [mexp_pkg::FIELD_BITS-1:0] modulus,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [mexp_pkg::FIELD_BITS-1:0] result
);
    import mexp_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    mexp_ctrl #(
        .WordBits (WordBits)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    mexp_datapath #(
        .WordBits (WordBits)
    ) u_datapath (
        .clk      (clk),
        .cmd      (cmd),
        .status   (status),
        .base     (base),
        .exponent (exponent),
        .modulus  (modulus),
        .result   (result)
    );

endmodule

@@ hdl/mexp_checker.sv @@
// Port-level checks of the modular exponentiation core, bound to the top level.
// Depends on mexp_pkg and modular_exponentiation_core_macros.svh.
`include "modular_exponentiation_core_macros.svh"

module mexp_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_ready,
    input logic                            out_valid,
    input logic                            out_ready,
    input logic [mexp_pkg::FIELD_BITS-1:0] result
);

    // A word held back by the consumer stays valid and unchanged.
    `MEC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(result), "result word changed while stalled")

    // Only one item is in work at a time.
    `MEC_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready, "input taken while an item is in work")

    // A result never follows its input word in the next cycle.
    `MEC_ASSERT_NEXT(a_no_early_result, in_valid && in_ready && !out_valid, !out_valid, "result appeared too early")

    // The handshake outputs are always known once reset has been released.
    `MEC_ASSERT_HOLDS(a_ready_known, !$isunknown(in_ready) && !$isunknown(out_valid), "handshake output unknown")

endmodule

bind modular_exponentiation_core mexp_checker u_mexp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .result    (result)
);

@@ tb/sv/tb.sv @@
// Self-checking testbench for modular_exponentiation_core: directed and random words,
// predicted by a square-and-multiply model of its own and checked in order.
// Depends on mexp_pkg and the modular_exponentiation_core RTL only.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mexp_pkg::*;

    typedef logic [FIELD_BITS-1:0] word_t;

    typedef struct {
        word_t base;
        word_t exponent;
        word_t modulus;
    } pow_req_t;

    logic  clk       = 1'b0;
    logic  rst_n     = 1'b0;
    logic  in_valid  = 1'b0;
    logic  out_ready = 1'b0;
    logic  hold_off  = 1'b0;
    word_t base      = '0;
    word_t exponent  = '0;
    word_t modulus   = '0;
    logic  in_ready;
    logic  out_valid;
    word_t result;

    pow_req_t operand_words[$];
    word_t    expected_residues[$];
    int       mismatches   = 0;
    int       results_seen = 0;
    int       burst_left   = 0;
    int       gap_left     = 0;
    int       stall_left   = 0;

    modular_exponentiation_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .base      (base),
        .exponent  (exponent),
        .modulus   (modulus),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .result    (result)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Right-to-left square-and-multiply; every product fits in 64 bits.
    function automatic word_t power_mod(word_t b, word_t e, word_t m);
        logic [63:0] acc;
        logic [63:0] sq;
        if (m == '0)
            return '0;
        acc = 64'd1 % m;
        sq  = b % m;
        for (int i = 0; i < FIELD_BITS; i++)
        begin
            if (e[i])
                acc = (acc * sq) % m;
            sq = (sq * sq) % m;
        end
        return acc[FIELD_BITS-1:0];
    endfunction

    function automatic word_t pick_operand();
        case ($urandom_range(0, 6))
            0: return word_t'($urandom_range(0, 3));
            1: return word_t'(32'hFFFF_FFFF - $urandom_range(0, 3));
            2: return word_t'(32'h1 << $urandom_range(0, 31));
            3: return word_t'($urandom_range(0, 65535));
            4: return word_t'($urandom | $urandom);
            default: return word_t'($urandom);
        endcase
    endfunction

    task automatic add_word(word_t b, word_t e, word_t m);
        pow_req_t req;
        req.base     = b;
        req.exponent = e;
        req.modulus  = m;
        operand_words.push_back(req);
    endtask

    task automatic flag_error(string msg);
        $display("[tb] mismatch: %s", msg);
        mismatches++;
    endtask

    // Sender: bursts of words separated by gaps that are mostly short but sometimes
    // long enough to leave the core idle.
    always @(posedge clk or negedge rst_n)
    begin : drive_words
        pow_req_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                expected_residues.push_back(power_mod(base, exponent, modulus));
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (operand_words.size() != 0)
                begin
                    nxt = operand_words.pop_front();
                    in_valid <= 1'b1;
                    base     <= nxt.base;
                    exponent <= nxt.exponent;
                    modulus  <= nxt.modulus;
                    if (burst_left == 0)
                        burst_left = $urandom_range(1, 8);
                    burst_left--;
                    if (burst_left == 0)
                    begin
                        case ($urandom_range(0, 9))
                            0, 1, 2, 3, 4: gap_left = 0;
                            9:             gap_left = $urandom_range(100, 1500);
                            default:       gap_left = $urandom_range(1, 20);
                        endcase
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: short random stalls, the odd long one, and quiet windows without any.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (stall_left > 0)
                stall_left--;
            else if ((results_seen % 64) < 48 && $urandom_range(0, 63) == 0)
                stall_left = ($urandom_range(0, 99) == 0) ? $urandom_range(200, 2500)
                                                          : $urandom_range(1, 40);
            out_ready <= !hold_off && stall_left == 0;
        end
    end

    // Hold the output off long enough for a finished word to sit in the output
    // register while the next one completes, so the input side has to stall.
    initial
    begin
        wait (results_seen >= 40);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (6000) @(posedge clk);
        hold_off <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (expected_residues.size() == 0)
                flag_error($sformatf("unexpected result %08h", result));
            else if (result !== expected_residues[0])
                flag_error($sformatf("result %08h, expected %08h", result,
                                     expected_residues.pop_front()));
            else
                void'(expected_residues.pop_front());
        end
    end

    initial
    begin
        word_t m;

        // Extremes and the special cases: zero exponent, modulus of one, base
        // divisible by the modulus, full-width products.
        add_word(32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF);
        add_word(32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0001);
        add_word(32'h0000_0000, 32'h0000_0000, 32'h0000_0001);
        add_word(32'h0000_3039, 32'h0000_0000, 32'h0000_0002);
        add_word(32'h0000_0005, 32'h0000_0001, 32'h0000_0001);
        add_word(32'h0000_0000, 32'h0000_0005, 32'h0000_0007);
        add_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFE);
        add_word(32'h0000_0002, 32'h8000_0000, 32'hFFFF_FFFB);
        add_word(32'h0000_0003, 32'hFFFF_FFFF, 32'hFFFF_FFFB);
        add_word(32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000);
        add_word(32'h0000_0007, 32'h0000_0002, 32'hFFFF_FFFF);
        add_word(32'hFFFF_FFFE, 32'h0000_0002, 32'hFFFF_FFFF);
        add_word(32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0003);
        add_word(32'h0000_0002, 32'h0000_000A, 32'h0000_03E8);
        add_word(32'h1234_5678, 32'h9ABC_DEF0, 32'h0000_FFFF);
        add_word(32'hDEAD_BEEF, 32'h0000_0001, 32'h0001_0000);
        add_word(32'hAAAA_AAAA, 32'h5555_5555, 32'h8000_0001);

        for (int n = 0; n < 252; n++)
        begin
            m = pick_operand();
            if (m == '0)
                m = 32'h1;
            add_word(pick_operand(), pick_operand(), m);
        end

        while (operand_words.size() != 0 || in_valid)
            @(posedge clk);
        while (expected_residues.size() != 0)
            @(posedge clk);
        repeat (2300) @(posedge clk);

        if (mismatches == 0)
            $display("[modular_exponentiation_core] OK");
        else
            $display("[modular_exponentiation_core] ERROR");
        $finish;
    end

    initial
    begin
        #60ms;
        $display("[modular_exponentiation_core] ERROR");
        $finish;
    end

endmodule
